@@ sv/omni3ik_pkg.sv @@
// Shared constants, widths and types for the three-wheel omni drive
// inverse kinematics pipeline. No dependencies; every other file imports it.
package omni3ik_pkg;

    // Input fixed-point format: signed, this many fraction bits.
    localparam int INPUT_FRAC_BITS = 14;

    // Port field widths.
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int ROT_W      = 16;
    localparam int FS_W       = 15;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int NUM_WHEELS = 3;

    // Wheel sums carry INPUT_FRAC_BITS + 16 fraction bits; 1.0 is 2^ONE_EXP.
    localparam int ONE_EXP = INPUT_FRAC_BITS + 16;

    // Largest wheel magnitude stays below 2^36 for any 16-bit inputs; the
    // magnitude word must also hold 1.0 itself.
    localparam int MAG_W  = (ONE_EXP + 1 > 36) ? ONE_EXP + 1 : 36;
    localparam int SUM_W  = MAG_W + 1;
    localparam int Q_W    = FS_W;
    localparam int DIV_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + FS_W;
    localparam int NUM_W  = DIV_W + Q_W;

    // Projection constants: cos(30 deg) in Q0.16 and the shifts that align
    // vel_y / 2, vel_y and turn_rate * spin gain (Q4.12) to the sum format.
    localparam int COS_W  = 16;
    localparam logic [COS_W-1:0] COS30_Q16 = 16'd56756;
    localparam int XT_W   = IN_W + COS_W + 1;
    localparam int RR_W   = IN_W + ROT_W + 1;
    localparam int YH_SH  = 15;
    localparam int YF_SH  = 16;
    localparam int ROT_SH = 4;

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << ONE_EXP;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] REG_SPIN_GAIN      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE     = 1'd1;
    localparam logic [ROT_W-1:0]      ROT_SCALE_RESET    = 16'd8118;
    localparam logic [FS_W-1:0]       FULL_SCALE_RESET   = 15'd8192;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [PROD_W-1:0]       t_prod;
    typedef logic [NUM_W-1:0]        t_num;
    typedef logic [DIV_W-1:0]        t_div;
    typedef logic [Q_W-1:0]          t_quo;

    // Control that travels beside the data through the back half of the pipe.
    typedef struct packed {
        logic valid;
        logic renorm;
    } t_tag;

endpackage

@@ sv/omni3_inverse_kinematics.sv @@
// Top level of the three-wheel omni drive inverse kinematics pipeline:
// configuration registers, stream handshake and output register.
// Depends on omni3ik_pkg, omni3ik_proj, omni3ik_norm and omni3ik_div.

// The block turns one velocity beat (vel_x, vel_y, turn_rate, signed Q2.14)
// into one beat of three wheel commands plus a renormalized flag. It accepts a
// beat every cycle while the output register is not stalled; the beat passes
// through two projection stages, four normalization stages, fifteen divider
// stages (one quotient bit each, the divider sets the depth) and the output
// register. The pipeline advances as one: while the output register holds a
// beat that is not taken, s_axis_tready is low. Write the spin gain and
// full_scale only when no beats are in flight.
module omni3_inverse_kinematics import omni3ik_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Velocity command stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // vel_x, vel_y, turn_rate
    // Wheel command stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // wheel_right_front, wheel_rear, wheel_left_front
    output logic [47:0]           m_axis_tdata,
    output logic [0:0]            m_axis_tuser   // renormalized
);

    logic [ROT_W-1:0]        r_spin_gain;
    logic [FS_W-1:0]         r_full_scale;
    logic                    r_out_valid;
    logic                    r_out_renorm;
    logic signed [OUT_W-1:0] r_wheel [NUM_WHEELS];

    logic                    en;
    logic signed [IN_W-1:0]  vel_x;
    logic signed [IN_W-1:0]  vel_y;
    logic signed [IN_W-1:0]  turn_rate;
    logic                    proj_valid;
    t_sum                    proj_sum [NUM_WHEELS];
    t_tag                    norm_tag;
    t_num                    norm_num [NUM_WHEELS];
    t_div                    norm_dvs;
    logic [NUM_WHEELS-1:0]   norm_neg;
    t_tag                    div_tag;
    t_quo                    div_quo [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   div_neg;
    logic signed [OUT_W-1:0] n_wheel [NUM_WHEELS];
    logic signed [OUT_W-1:0] quo_ext [NUM_WHEELS];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_gain  <= ROT_SCALE_RESET;
            r_full_scale <= FULL_SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPIN_GAIN:  r_spin_gain  <= i_cfg_wdata[ROT_W-1:0];
                REG_FULL_SCALE: r_full_scale <= i_cfg_wdata[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipe moves whenever the output register is free or drained.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign vel_x     = s_axis_tdata[IN_W-1:0];
    assign vel_y     = s_axis_tdata[2*IN_W-1:IN_W];
    assign turn_rate = s_axis_tdata[3*IN_W-1:2*IN_W];

    omni3ik_proj u_proj (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (s_axis_tvalid),
        .i_vel_x     (vel_x),
        .i_vel_y     (vel_y),
        .i_turn_rate (turn_rate),
        .i_spin_gain (r_spin_gain),
        .o_valid     (proj_valid),
        .o_sum       (proj_sum)
    );

    omni3ik_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (proj_valid),
        .i_sum        (proj_sum),
        .i_full_scale (r_full_scale),
        .o_tag        (norm_tag),
        .o_num        (norm_num),
        .o_dvs        (norm_dvs),
        .o_neg        (norm_neg)
    );

    omni3ik_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (norm_tag),
        .i_num   (norm_num),
        .i_dvs   (norm_dvs),
        .i_neg   (norm_neg),
        .o_tag   (div_tag),
        .o_quo   (div_quo),
        .o_neg   (div_neg)
    );

    // Restore the sign. The quotient never exceeds full_scale because every
    // wheel magnitude is at most the divisor, so no clamp is needed.
    always_comb begin
        for (int j = 0; j < NUM_WHEELS; j++) begin
            quo_ext[j] = OUT_W'(div_quo[j]);
            n_wheel[j] = div_neg[j] ? -quo_ext[j] : quo_ext[j];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_renorm <= div_tag.renorm;
            r_wheel      <= n_wheel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_wheel[2], r_wheel[1], r_wheel[0]};
    assign m_axis_tuser  = r_out_renorm;

`ifndef ASSERT_OFF
    // A held result must stop new beats from entering the pipe.
    a_top_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");
`endif

endmodule

@@ sv/omni3ik_proj.sv @@
// Projection stages: body velocity onto the three wheel axes plus rotation.
// Two register stages (products, then sums). Depends on omni3ik_pkg.
module omni3ik_proj import omni3ik_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [IN_W-1:0]  i_vel_x,
    input  logic signed [IN_W-1:0]  i_vel_y,
    input  logic signed [IN_W-1:0]  i_turn_rate,
    input  logic [ROT_W-1:0]        i_spin_gain,
    output logic                    o_valid,
    output t_sum                    o_sum [NUM_WHEELS]
);

    logic                   r_vld1;
    logic                   r_vld2;
    logic signed [XT_W-1:0] r_xterm;
    logic signed [RR_W-1:0] r_rot;
    logic signed [IN_W-1:0] r_vel_y;
    t_sum                   r_sum [NUM_WHEELS];

    logic signed [XT_W-1:0] n_xterm;
    logic signed [RR_W-1:0] n_rot;
    t_sum                   xt;
    t_sum                   yh;
    t_sum                   yf;
    t_sum                   rt;
    t_sum                   n_sum [NUM_WHEELS];

    // Stage one: the two real multiplications.
    assign n_xterm = i_vel_x * $signed({1'b0, COS30_Q16});
    assign n_rot   = i_turn_rate * $signed({1'b0, i_spin_gain});

    // Stage two: align every term to the sum format and add per wheel.
    assign xt = SUM_W'(r_xterm);
    assign yh = SUM_W'($signed({r_vel_y, {YH_SH{1'b0}}}));
    assign yf = SUM_W'($signed({r_vel_y, {YF_SH{1'b0}}}));
    assign rt = SUM_W'($signed({r_rot, {ROT_SH{1'b0}}}));

    assign n_sum[0] = xt + yh + rt;
    assign n_sum[1] = rt - yf;
    assign n_sum[2] = rt - xt + yh;

    // Valid bits follow the data and freeze on a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xterm <= n_xterm;
            r_rot   <= n_rot;
            r_vel_y <= i_vel_y;
            r_sum   <= n_sum;
        end
    end

    assign o_valid = r_vld2;
    assign o_sum   = r_sum;

endmodule

@@ sv/omni3ik_norm.sv @@
// Normalization stages: wheel magnitudes, largest magnitude, divisor choice,
// scaling by full_scale and the rounding numerator. Depends on omni3ik_pkg.
module omni3ik_norm import omni3ik_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_sum                  i_sum [NUM_WHEELS],
    input  logic [FS_W-1:0]       i_full_scale,
    output t_tag                  o_tag,
    output t_num                  o_num [NUM_WHEELS],
    output t_div                  o_dvs,
    output logic [NUM_WHEELS-1:0] o_neg
);

    logic                  r_vld3;
    logic                  r_vld4;
    logic                  r_vld5;
    logic                  r_vld6;
    t_mag                  r_mag3 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg3;
    t_mag                  r_mag4 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg4;
    t_mag                  r_den4;
    logic                  r_ren4;
    t_prod                 r_prod5 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg5;
    t_mag                  r_den5;
    logic                  r_ren5;
    t_num                  r_num6 [NUM_WHEELS];
    t_div                  r_dvs6;
    logic [NUM_WHEELS-1:0] r_neg6;
    logic                  r_ren6;

    t_mag                  n_mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] n_neg;
    t_sum                  abs_val [NUM_WHEELS];
    t_mag                  max01;
    t_mag                  max_all;
    logic                  n_ren;
    t_mag                  n_den;
    t_prod                 n_prod [NUM_WHEELS];
    t_num                  n_num [NUM_WHEELS];

    // Stage three: sign and magnitude of each wheel sum.
    always_comb begin
        for (int j = 0; j < NUM_WHEELS; j++) begin
            n_neg[j]   = i_sum[j][SUM_W-1];
            abs_val[j] = n_neg[j] ? -i_sum[j] : i_sum[j];
            n_mag[j]   = abs_val[j][MAG_W-1:0];
        end
    end

    // Stage four: largest magnitude; divide by it only when it exceeds 1.0.
    assign max01   = (r_mag3[0] > r_mag3[1]) ? r_mag3[0] : r_mag3[1];
    assign max_all = (r_mag3[2] > max01) ? r_mag3[2] : max01;
    assign n_ren   = max_all > ONE_MAG;
    assign n_den   = n_ren ? max_all : ONE_MAG;

    // Stage five: scale to output units; stage six: 2*|v|*fs + D so that the
    // floor of the quotient by 2*D rounds half away from zero.
    always_comb begin
        for (int j = 0; j < NUM_WHEELS; j++) begin
            n_prod[j] = PROD_W'(r_mag4[j]) * PROD_W'(i_full_scale);
            n_num[j]  = {r_prod5[j], 1'b0} + NUM_W'(r_den5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_valid;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag3  <= n_mag;
            r_neg3  <= n_neg;
            r_mag4  <= r_mag3;
            r_neg4  <= r_neg3;
            r_den4  <= n_den;
            r_ren4  <= n_ren;
            r_prod5 <= n_prod;
            r_neg5  <= r_neg4;
            r_den5  <= r_den4;
            r_ren5  <= r_ren4;
            r_num6  <= n_num;
            r_dvs6  <= {r_den5, 1'b0};
            r_neg6  <= r_neg5;
            r_ren6  <= r_ren5;
        end
    end

    assign o_tag.valid  = r_vld6;
    assign o_tag.renorm = r_ren6;
    assign o_num        = r_num6;
    assign o_dvs        = r_dvs6;
    assign o_neg        = r_neg6;

endmodule

@@ sv/omni3ik_div.sv @@
// Pipelined restoring divider for the three wheels, one quotient bit per
// stage over Q_W stages, sharing one divisor per beat. Depends on omni3ik_pkg.
module omni3ik_div import omni3ik_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_tag                  i_tag,
    input  t_num                  i_num [NUM_WHEELS],
    input  t_div                  i_dvs,
    input  logic [NUM_WHEELS-1:0] i_neg,
    output t_tag                  o_tag,
    output t_quo                  o_quo [NUM_WHEELS],
    output logic [NUM_WHEELS-1:0] o_neg
);

    // Per stage: partial remainder, and a word that holds the numerator bits
    // still to come in its top and the quotient bits found so far in its bottom.
    logic [Q_W-1:0]        r_vld;
    logic [Q_W-1:0]        r_ren;
    logic [NUM_WHEELS-1:0] r_neg [Q_W];
    t_quo                  r_lq  [Q_W][NUM_WHEELS];
    t_div                  r_rem [Q_W-1][NUM_WHEELS];
    t_div                  r_dvs [Q_W-1];

    t_div                  c_rem [Q_W][NUM_WHEELS];
    t_quo                  c_lq  [Q_W][NUM_WHEELS];
    t_div                  c_dvs [Q_W];
    logic [DIV_W:0]        c_trial [Q_W][NUM_WHEELS];
    logic [DIV_W:0]        c_diff  [Q_W][NUM_WHEELS];
    logic                  c_fit   [Q_W][NUM_WHEELS];
    t_quo                  n_lq  [Q_W][NUM_WHEELS];
    t_div                  n_rem [Q_W-1][NUM_WHEELS];

    // Stage inputs: the first stage takes the numerator split at Q_W bits.
    always_comb begin
        c_dvs[0] = i_dvs;
        for (int j = 0; j < NUM_WHEELS; j++) begin
            c_rem[0][j] = i_num[j][NUM_W-1:Q_W];
            c_lq[0][j]  = i_num[j][Q_W-1:0];
        end
        for (int k = 1; k < Q_W; k++) begin
            c_dvs[k] = r_dvs[k-1];
            for (int j = 0; j < NUM_WHEELS; j++) begin
                c_rem[k][j] = r_rem[k-1][j];
                c_lq[k][j]  = r_lq[k-1][j];
            end
        end
    end

    // One trial subtraction per stage and wheel.
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            for (int j = 0; j < NUM_WHEELS; j++) begin
                c_trial[k][j] = {c_rem[k][j], c_lq[k][j][Q_W-1]};
                c_diff[k][j]  = c_trial[k][j] - {1'b0, c_dvs[k]};
                c_fit[k][j]   = c_trial[k][j] >= {1'b0, c_dvs[k]};
                n_lq[k][j]    = {c_lq[k][j][Q_W-2:0], c_fit[k][j]};
            end
        end
        for (int k = 0; k < Q_W - 1; k++) begin
            for (int j = 0; j < NUM_WHEELS; j++) begin
                n_rem[k][j] = c_fit[k][j] ? c_diff[k][j][DIV_W-1:0]
                                          : c_trial[k][j][DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_tag.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ren    <= {r_ren[Q_W-2:0], i_tag.renorm};
            r_neg[0] <= i_neg;
            for (int k = 1; k < Q_W; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_lq <= n_lq;
            for (int k = 0; k < Q_W - 1; k++) begin
                r_dvs[k] <= c_dvs[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

    assign o_tag.valid  = r_vld[Q_W-1];
    assign o_tag.renorm = r_ren[Q_W-1];
    assign o_quo        = r_lq[Q_W-1];
    assign o_neg        = r_neg[Q_W-1];

`ifndef ASSERT_OFF
    // The quotient fits in Q_W bits only if the leading numerator part is
    // already below the divisor.
    a_div_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag.valid |-> (i_num[0][NUM_W-1:Q_W] < i_dvs)
                     && (i_num[1][NUM_W-1:Q_W] < i_dvs)
                     && (i_num[2][NUM_W-1:Q_W] < i_dvs))
        else $error("divider entry remainder not below divisor");

    // Partial remainders stay below the divisor, checked at the last remainder stage.
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[Q_W-2] |-> (r_rem[Q_W-2][0] < r_dvs[Q_W-2])
                      && (r_rem[Q_W-2][1] < r_dvs[Q_W-2])
                      && (r_rem[Q_W-2][2] < r_dvs[Q_W-2]))
        else $error("divider remainder escaped its bound");

    // A stall freezes the valid and flag columns of the divider.
    a_div_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld) && $stable(r_ren))
        else $error("divider control moved during a stall");
`endif

endmodule
